### src/assert_macros.svh
// Assertion macros used by the port checker of the escaper.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion gated off while reset is active.
`define ASSERT_RST(label, clk_s, rst_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Concurrent assertion checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk_s, prop, msg) \
    label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

### src/hee_pkg.sv
// Shared types, constants and character helpers for the HTML entity escaper.
// No dependencies; imported by the front, queue and back modules.
package hee_pkg;

    localparam int ACC_W     = 21;
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int POS_W     = 4;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PLAIN = 2'd0;
    localparam kind_t KIND_BR    = 2'd1;
    localparam kind_t KIND_DEC   = 2'd2;
    localparam kind_t KIND_HEX   = 2'd3;

    typedef struct packed {
        kind_t            kind;
        logic [ACC_W-1:0] value;
    } cmd_t;

    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_B    = 8'h62;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_ZERO = 8'h30;

    localparam logic [POS_W-1:0] POS_NEVER = 4'd15;

    function automatic logic is_plain(input logic [7:0] c);
        return c inside {[8'd48:8'd57], [8'd65:8'd90], [8'd97:8'd122], [8'd32:8'd43],
                         [8'd45:8'd47], 8'd61, 8'd63, 8'd64, [8'd123:8'd126]};
    endfunction

    function automatic logic [POS_W-1:0] last_pos(input kind_t kind);
        logic [POS_W-1:0] p;
        case (kind)
            KIND_PLAIN: p = 4'd0;
            KIND_BR:    p = 4'd3;
            KIND_DEC:   p = 4'd5;
            KIND_HEX:   p = 4'd9;
            default:    p = 4'd0;
        endcase
        return p;
    endfunction

    // Position after which leading digits are skipped.
    function automatic logic [POS_W-1:0] jump_from(input kind_t kind);
        logic [POS_W-1:0] p;
        case (kind)
            KIND_DEC: p = 4'd1;
            KIND_HEX: p = 4'd2;
            default:  p = POS_NEVER;
        endcase
        return p;
    endfunction

    // Position of the first digit actually shown.
    function automatic logic [POS_W-1:0] jump_to(input cmd_t cmd);
        logic [23:0]      v24;
        logic [2:0]       top;
        logic [POS_W-1:0] p;
        v24 = {3'b000, cmd.value};
        top = 3'd0;
        for (int k = 1; k < 6; k++) begin
            if (v24[k*4 +: 4] != 4'd0) top = 3'(k);
        end
        case (cmd.kind)
            KIND_HEX: p = 4'd8 - {1'b0, top};
            KIND_DEC: p = (cmd.value[6:0] >= 7'd100) ? 4'd2 :
                          (cmd.value[6:0] >= 7'd10)  ? 4'd3 : 4'd4;
            default:  p = 4'd0;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (CH_ZERO + {4'b0, n}) : (8'd87 + {4'b0, n});
    endfunction

    function automatic logic [7:0] char_at(input cmd_t cmd, input logic [POS_W-1:0] pos);
        logic [23:0] v24;
        logic [6:0]  c;
        logic        hund;
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        logic [7:0]  ch;
        v24  = {3'b000, cmd.value};
        c    = cmd.value[6:0];
        hund = (c >= 7'd100);
        rem  = hund ? (c - 7'd100) : c;
        // divide by ten via reciprocal, exact for values below 100
        prod = 15'(rem) * 15'd205;
        tens = prod[14:11];
        ones = rem - 7'(tens) * 7'd10;
        case (cmd.kind)
            KIND_PLAIN: ch = cmd.value[7:0];
            KIND_BR:
                case (pos)
                    4'd0:    ch = CH_LT;
                    4'd1:    ch = CH_B;
                    4'd2:    ch = CH_R;
                    default: ch = CH_GT;
                endcase
            KIND_DEC:
                case (pos)
                    4'd0:    ch = CH_AMP;
                    4'd1:    ch = CH_HASH;
                    4'd2:    ch = CH_ZERO + {7'b0, hund};
                    4'd3:    ch = CH_ZERO + {4'b0, tens};
                    4'd4:    ch = CH_ZERO + {4'b0, ones[3:0]};
                    default: ch = CH_SEMI;
                endcase
            KIND_HEX:
                case (pos)
                    4'd0:    ch = CH_AMP;
                    4'd1:    ch = CH_HASH;
                    4'd2:    ch = CH_X;
                    4'd3:    ch = hex_char(v24[23:20]);
                    4'd4:    ch = hex_char(v24[19:16]);
                    4'd5:    ch = hex_char(v24[15:12]);
                    4'd6:    ch = hex_char(v24[11:8]);
                    4'd7:    ch = hex_char(v24[7:4]);
                    4'd8:    ch = hex_char(v24[3:0]);
                    default: ch = CH_SEMI;
                endcase
            default: ch = cmd.value[7:0];
        endcase
        return ch;
    endfunction

endpackage

### src/hee_cmd_fifo.sv
// Short command queue between the classifier front and the serializer back.
// Depends on hee_pkg for cmd_t and the queue depth.
module hee_cmd_fifo
    import hee_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wdata,
    output logic full,
    input  logic pop,
    output cmd_t rdata,
    output logic empty
);

    cmd_t                 slot_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_PTR_W:0]   count_reg, count_next;
    logic                 push_ok;
    logic                 pop_ok;

    assign full    = (count_reg == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (CMD_PTR_W+1)'(push_ok) - (CMD_PTR_W+1)'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### src/hee_front.sv
// Input side: gathers multibyte sequences and classifies each byte into a command.
// Depends on hee_pkg; feeds hee_cmd_fifo.
module hee_front
    import hee_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] text_byte,
    input  logic       end_of_string,
    output logic       cmd_push,
    output cmd_t       cmd
);

    logic [1:0]       pending_reg, pending_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] acc_shift;
    logic             cmd_valid;

    always_comb
    begin
        acc_shift    = {acc_reg[ACC_W-7:0], text_byte[5:0]};
        pending_next = pending_reg;
        acc_next     = acc_reg;
        cmd_valid    = 1'b0;
        cmd.kind     = KIND_PLAIN;
        cmd.value    = {{(ACC_W-8){1'b0}}, text_byte};

        if (pending_reg != 2'd0)
        begin
            pending_next = pending_reg - 2'd1;
            if (pending_next == 2'd0)
            begin
                // sequence complete: a zero code point emits nothing
                cmd.kind  = KIND_HEX;
                cmd.value = acc_shift;
                cmd_valid = (acc_shift != '0);
                acc_next  = '0;
            end
            else
            begin
                acc_next = acc_shift;
            end
        end
        else if (text_byte[7])
        begin
            if (text_byte < 8'd224)
            begin
                pending_next = 2'd1;
                acc_next     = {{(ACC_W-5){1'b0}}, text_byte[4:0]};
            end
            else if (text_byte < 8'd240)
            begin
                pending_next = 2'd2;
                acc_next     = {{(ACC_W-4){1'b0}}, text_byte[3:0]};
            end
            else
            begin
                pending_next = 2'd3;
                acc_next     = {{(ACC_W-3){1'b0}}, text_byte[2:0]};
            end
        end
        else if (text_byte == CH_NL)
        begin
            cmd.kind  = KIND_BR;
            cmd_valid = 1'b1;
        end
        else if (is_plain(text_byte))
        begin
            cmd.kind  = KIND_PLAIN;
            cmd_valid = 1'b1;
        end
        else
        begin
            cmd.kind  = KIND_DEC;
            cmd_valid = 1'b1;
        end

        // drop a sequence cut off by end of string
        if (end_of_string && pending_next != 2'd0)
        begin
            pending_next = 2'd0;
            acc_next     = '0;
        end
    end

    assign cmd_push = accept && cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            acc_reg     <= '0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
        end
    end

endmodule

### src/hee_back.sv
// Output side: serializes one command per run into bytes and holds the output word.
// Depends on hee_pkg; drains hee_cmd_fifo.
module hee_back
    import hee_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       head_empty,
    output logic       head_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    cmd_t             cur_reg, cur_next;
    logic             active_reg, active_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] jump_reg, jump_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             last_reg, last_next;
    logic             advance;
    logic             emit;
    logic             at_last;
    logic             load;

    assign advance = !out_valid_reg || pop;
    assign emit    = active_reg && advance;
    assign at_last = (pos_reg == last_pos(cur_reg.kind));
    assign load    = !head_empty && (!active_reg || (emit && at_last));
    assign head_pop = load;

    always_comb
    begin
        cur_next       = cur_reg;
        active_next    = active_reg;
        pos_next       = pos_reg;
        jump_next      = jump_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = char_at(cur_reg, pos_reg);
            last_next      = at_last;
            // skip leading zero digits
            pos_next       = (pos_reg == jump_from(cur_reg.kind)) ? jump_reg : pos_reg + 1'b1;
            if (at_last)
            begin
                active_next = 1'b0;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        if (load)
        begin
            cur_next    = head;
            active_next = 1'b1;
            pos_next    = '0;
            jump_next   = jump_to(head);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        jump_reg     <= jump_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign empty       = !out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

endmodule

### src/html_entity_escaper_core.sv
// HTML escaper: one text byte in per push, zero to ten escaped bytes out, last_of_run
// marking the final byte each input causes. Multibyte sequences become hex entities,
// newline becomes <br>, other unsafe ASCII becomes a decimal entity. The front accepts
// one byte per cycle while its four-word command queue has room; the serializer sends
// one output byte per cycle while pop takes the output word. A plain byte gives one
// output byte, <br> four, a decimal entity four to six and a hex entity five to ten.
// Lead and continuation bytes that complete nothing are consumed at the front only.
// Depends on hee_pkg, hee_front, hee_cmd_fifo and hee_back.
module html_entity_escaper_core
    import hee_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] text_byte,
    input  logic       end_of_string,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic cmd_push;
    cmd_t cmd;
    logic q_full;
    cmd_t q_head;
    logic q_empty;
    logic q_pop;

    assign full = q_full;

    hee_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (push && !q_full),
        .text_byte     (text_byte),
        .end_of_string (end_of_string),
        .cmd_push      (cmd_push),
        .cmd           (cmd)
    );

    hee_cmd_fifo u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_head),
        .empty (q_empty)
    );

    hee_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .head_empty  (q_empty),
        .head_pop    (q_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

### src/hee_port_checker.sv
// Port-level checks on the escaper's output word stream, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module hee_port_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       last_of_run
);

    // hold a waiting word until it is taken
    `ASSERT_RST(a_out_hold, clk, rst_n,
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_of_run)),
        "output word changed while stalled")
    // a semicolon only ever closes an entity
    `ASSERT_RST(a_semi_last, clk, rst_n,
        (!empty && out_byte == 8'h3B) |-> last_of_run,
        "semicolon not marked last")
    // a '<' only ever opens <br>
    `ASSERT_RST(a_lt_not_last, clk, rst_n,
        (!empty && out_byte == 8'h3C) |-> !last_of_run,
        "'<' marked last")
    // reset clears the output word by the following edge
    `ASSERT_ALWAYS(a_reset_empty, clk,
        !rst_n |=> empty,
        "output not empty after reset")

endmodule

bind html_entity_escaper_core hee_port_checker u_port_checker (.*);

### bench/hee_escape_checker.sv
// Checker for the HTML entity escaper: watches both queue sides, predicts the escaped
// words for every accepted text byte and compares each popped word in order.
// Depends on hee_pkg for the character constants and the accumulator width.
`timescale 1ns / 100ps

module hee_escape_checker
    import hee_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] text_byte,
    input  logic       end_of_string,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] out_byte,
    input  logic       last_of_run,
    output int         mismatches,
    output int         pending
);

    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam int         SHOWN_MAX  = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } esc_word_t;

    esc_word_t        expected_words[$];
    logic [1:0]       cont_left;
    logic [ACC_W-1:0] code_acc;
    int               err_count;
    int               word_index;

    function automatic logic passes_as_is(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z")
            || (c >= " " && c <= "/" && c != ",") || c == "=" || c == "?" || c == "@"
            || (c >= "{" && c <= "~");
    endfunction

    // Update the decoder state for one text byte and queue the words it produces.
    function automatic void predict_escape(input logic [7:0] b, input logic eos);
        logic [7:0]  run[$];
        logic [23:0] v24;
        logic [3:0]  nib;
        int          top;
        int          c;
        if (cont_left != 2'd0) begin
            code_acc  = {code_acc[ACC_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                if (code_acc != '0) begin
                    v24 = {3'b000, code_acc};
                    top = 5;
                    while (top > 0 && v24[top*4 +: 4] == 4'd0) top--;
                    run.push_back(CH_AMP);
                    run.push_back(CH_HASH);
                    run.push_back(CH_X);
                    for (int k = top; k >= 0; k--) begin
                        nib = v24[k*4 +: 4];
                        run.push_back((nib < 4'd10) ? CH_ZERO + {4'b0, nib}
                                                    : CH_LOWER_A + {4'b0, nib} - 8'd10);
                    end
                    run.push_back(CH_SEMI);
                end
                code_acc = '0;
            end
        end else if (b >= 8'd128) begin
            // lead byte keeps only the bits below its length marker
            if (b < 8'd224) begin
                code_acc  = ACC_W'(b[4:0]);
                cont_left = 2'd1;
            end else if (b < 8'd240) begin
                code_acc  = ACC_W'(b[3:0]);
                cont_left = 2'd2;
            end else begin
                code_acc  = ACC_W'(b[2:0]);
                cont_left = 2'd3;
            end
        end else if (b == CH_NL) begin
            run.push_back(CH_LT);
            run.push_back(CH_B);
            run.push_back(CH_R);
            run.push_back(CH_GT);
        end else if (passes_as_is(b)) begin
            run.push_back(b);
        end else begin
            c = int'(b);
            run.push_back(CH_AMP);
            run.push_back(CH_HASH);
            if (c >= 100) run.push_back(CH_ZERO + 8'(c / 100));
            if (c >= 10) run.push_back(CH_ZERO + 8'((c / 10) % 10));
            run.push_back(CH_ZERO + 8'(c % 10));
            run.push_back(CH_SEMI);
        end
        // drop a sequence cut short by the end of the string
        if (eos && cont_left != 2'd0) begin
            cont_left = 2'd0;
            code_acc  = '0;
        end
        foreach (run[i]) expected_words.push_back('{ch: run[i], last: (i == run.size() - 1)});
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        esc_word_t want;
        if (!rst_n)
        begin
            expected_words.delete();
            cont_left  = 2'd0;
            code_acc   = '0;
            err_count  = 0;
            word_index = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (push && !full) predict_escape(text_byte, end_of_string);
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    err_count++;
                    if (err_count <= SHOWN_MAX)
                        $display("unexpected word %0d: out_byte %h last_of_run %b",
                                 word_index, out_byte, last_of_run);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (out_byte !== want.ch || last_of_run !== want.last)
                    begin
                        err_count++;
                        if (err_count <= SHOWN_MAX)
                            $display("mismatch on word %0d: out_byte exp %h got %h, last_of_run exp %b got %b",
                                     word_index, want.ch, out_byte, want.last, last_of_run);
                    end
                end
                word_index++;
            end
            mismatches <= err_count;
            pending    <= expected_words.size();
        end
    end

endmodule

### bench/tb_html_entity_escaper_core.sv
// Top of the escaper testbench: clock, reset, byte stimulus, pop stalls and verdict.
// Depends on html_entity_escaper_core, hee_pkg and hee_escape_checker.
`timescale 1ns / 100ps

module tb_html_entity_escaper_core;
    import hee_pkg::*;

    localparam int RANDOM_ITEMS = 86;
    localparam int STALL_LIMIT  = 400;
    localparam int TAIL_CYCLES  = 20;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] text_byte;
    logic       end_of_string;
    logic       empty;
    logic       pop;
    logic [7:0] out_byte;
    logic       last_of_run;

    int mismatches;
    int pending;
    int bytes_sent;
    int quiet_cycles;
    int pop_stall_left;
    bit drain_phase;

    html_entity_escaper_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .text_byte    (text_byte),
        .end_of_string(end_of_string),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run)
    );

    hee_escape_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .text_byte    (text_byte),
        .end_of_string(end_of_string),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Pop side: stall in random bursts until the drain phase.
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_stall_left > 0)
        begin
            pop_stall_left--;
            pop <= 1'b0;
        end
        else if (!drain_phase && $urandom_range(0, 5) == 0)
        begin
            pop_stall_left = $urandom_range(0, 3);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    // Abort when nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        if (!drain_phase && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 4);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push          <= 1'b1;
        text_byte     <= b;
        end_of_string <= eos;
        @(posedge clk);
        while (full) @(posedge clk);
        bytes_sent++;
    endtask

    // One random unit: mostly plain text and well-formed multibyte sequences,
    // some cut short, some with odd continuation bytes, a few stray bytes.
    task automatic send_random_unit();
        int         pick;
        int         len;
        int         cut;
        bit         zero_cp;
        logic [7:0] b;
        pick = $urandom_range(0, 19);
        if (pick < 8)
            send_byte(8'($urandom_range(1, 127)), $urandom_range(0, 7) == 0);
        else if (pick < 10)
            send_byte(CH_NL, $urandom_range(0, 7) == 0);
        else if (pick == 10)
            send_byte(8'($urandom_range(1, 255)), $urandom_range(0, 3) == 0);
        else
        begin
            len     = $urandom_range(2, 4);
            zero_cp = ($urandom_range(0, 7) == 0);
            cut     = ($urandom_range(0, 6) == 0) ? $urandom_range(1, len - 1) : 0;
            case (len)
                2:       b = zero_cp ? 8'hC0 : 8'($urandom_range(128, 223));
                3:       b = zero_cp ? 8'hE0 : 8'($urandom_range(224, 239));
                default: b = zero_cp ? 8'hF0 : 8'($urandom_range(240, 255));
            endcase
            for (int i = 1; i <= len; i++)
            begin
                if (i > 1)
                begin
                    if (zero_cp)
                        b = 8'h80;
                    else if ($urandom_range(0, 9) == 0)
                        b = 8'($urandom_range(1, 255));
                    else
                        b = 8'($urandom_range(128, 191));
                end
                if (i == cut)
                begin
                    send_byte(b, 1'b1);
                    break;
                end
                send_byte(b, (i == len) && ($urandom_range(0, 7) == 0));
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        push           = 1'b0;
        text_byte      = 8'h00;
        end_of_string  = 1'b0;
        bytes_sent     = 0;
        pop_stall_left = 0;
        drain_phase    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // plain, newline and decimal-entity singles, including a zero byte
        send_byte("Z", 1'b0);
        send_byte("0", 1'b0);
        send_byte(" ", 1'b0);
        send_byte(",", 1'b0);
        send_byte("/", 1'b0);
        send_byte("~", 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        // two, three and four byte sequences, the last one all ones
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // zero code point emits nothing and skips nothing
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        // sequence cut by end of string, then a lead byte that is itself last
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hDF, 1'b1);

        while (bytes_sent < 24 + RANDOM_ITEMS)
        begin
            if (bytes_sent >= 24 + (RANDOM_ITEMS * 4) / 5) drain_phase = 1'b1;
            send_random_unit();
        end
        push <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
